// ----- hdl/sha1md_pkg.sv -----
// Shared types and constants of the SHA-1 message digest block.
package sha1md_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;

	localparam word_t INIT_H0 = 32'h6745_2301;
	localparam word_t INIT_H1 = 32'hefcd_ab89;
	localparam word_t INIT_H2 = 32'h98ba_dcfe;
	localparam word_t INIT_H3 = 32'h1032_5476;
	localparam word_t INIT_H4 = 32'hc3d2_e1f0;

	localparam word_t K_CH     = 32'h5a82_7999;
	localparam word_t K_PAR1   = 32'h6ed9_eba1;
	localparam word_t K_MAJ    = 32'h8f1b_bcdc;
	localparam word_t K_PAR2   = 32'hca62_c1d6;

	localparam byte_t PAD_MARK = 8'h80;

	localparam int unsigned ROUNDS      = 80;
	localparam int unsigned RND_W       = 7;
	localparam int unsigned LEN_POS     = 56;

endpackage

// ----- hdl/sha1md_if.sv -----
// Valid/ready channel interfaces for message items and digest items.
interface sha1md_msg_if;
	logic                 valid;
	logic                 ready;
	sha1md_pkg::byte_t    data_byte;
	logic                 byte_valid;
	logic                 last;

	modport source (output valid, output data_byte, output byte_valid, output last,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input last,
		output ready);
endinterface

interface sha1md_digest_if;
	logic                 valid;
	logic                 ready;
	sha1md_pkg::word_t    hash_word_0;
	sha1md_pkg::word_t    hash_word_1;
	sha1md_pkg::word_t    hash_word_2;
	sha1md_pkg::word_t    hash_word_3;
	sha1md_pkg::word_t    hash_word_4;

	modport source (output valid, output hash_word_0, output hash_word_1,
		output hash_word_2, output hash_word_3, output hash_word_4, input ready);
	modport sink (input valid, input hash_word_0, input hash_word_1,
		input hash_word_2, input hash_word_3, input hash_word_4, output ready);
endinterface

// ----- hdl/sha1_message_digest.sv -----
// SHA-1 message digest: byte input, iterative round unit, digest output.
//
// The msg channel takes one item per accepted handshake: a message byte when
// byte_valid is high, and last high on the final item of a message. An item
// with byte_valid low and last high closes an empty message or tail.
// Each byte is taken while the block is ready. The 64th byte of a
// block starts the compression: 80 rounds at one round per cycle through a
// single round adder, then a fold into the chaining value. After the last
// item the block generates the padding one byte per cycle and compresses
// one or two more blocks, then puts the five digest words on the digest channel.
// The digest sits in an output register, so a new message may start while it
// waits; if a second digest is ready before the first has been taken, the
// block holds in its fold cycle until the receiver takes the first one.
// Reset returns the chaining value to its initial value, clears the byte
// count and drops any pending digest.
module sha1_message_digest (
	input  logic                    clk,
	input  logic                    arst_n,
	sha1md_msg_if.sink              msg,
	sha1md_digest_if.source         digest
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FOLD  = 3'd3;

	localparam int unsigned RND_W = sha1md_pkg::RND_W;

	logic [2:0]             state_q;
	logic [RND_W-1:0]       rnd_q;
	logic [63:0]            byte_count_q;
	logic [5:0]             pad_q;
	logic                   first_q;
	logic                   len_phase_q;
	logic                   done_q;
	logic                   pad_mode_q;
	logic                   out_valid_q;
	sha1md_pkg::word_t      chain_q [5];
	sha1md_pkg::word_t      hash_q [5];
	sha1md_pkg::word_t      w_q [16];
	logic [23:0]            acc_q;
	sha1md_pkg::word_t      a_q, b_q, c_q, d_q, e_q;

	logic                   msg_fire;
	logic                   push_en;
	sha1md_pkg::byte_t      push_byte;
	logic [5:0]             push_pos;
	logic [5:0]             new_pos;
	logic [63:0]            bit_len;
	sha1md_pkg::byte_t      pad_byte;
	logic                   start_round;
	logic                   fold_emit;
	sha1md_pkg::word_t      w_new;
	sha1md_pkg::word_t      wt;
	sha1md_pkg::word_t      f_val;
	sha1md_pkg::word_t      k_val;
	sha1md_pkg::word_t      t_val;
	sha1md_pkg::word_t      sum [5];

	assign msg.ready    = (state_q == ST_IDLE);
	assign msg_fire     = msg.valid && msg.ready;
	assign digest.valid = out_valid_q;
	assign digest.hash_word_0 = hash_q[0];
	assign digest.hash_word_1 = hash_q[1];
	assign digest.hash_word_2 = hash_q[2];
	assign digest.hash_word_3 = hash_q[3];
	assign digest.hash_word_4 = hash_q[4];

	assign new_pos = byte_count_q[5:0] + 6'(msg.byte_valid);
	assign bit_len = {byte_count_q[60:0], 3'b000};

	always_comb begin
		if (first_q) begin
			pad_byte = sha1md_pkg::PAD_MARK;
		end else if (len_phase_q && (pad_q >= 6'(sha1md_pkg::LEN_POS))) begin
			pad_byte = bit_len[{~pad_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = '0;
		end
	end

	always_comb begin
		push_en   = 1'b0;
		push_byte = msg.data_byte;
		push_pos  = byte_count_q[5:0];
		if (state_q == ST_IDLE) begin
			push_en = msg_fire && msg.byte_valid;
		end else if (state_q == ST_PAD) begin
			push_en   = 1'b1;
			push_byte = pad_byte;
			push_pos  = pad_q;
		end
	end

	assign start_round = push_en && (push_pos == 6'h3f);
	assign fold_emit   = (state_q == ST_FOLD) && done_q && (!out_valid_q || digest.ready);

	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign wt    = (rnd_q < RND_W'(16)) ? w_q[0] : w_new;

	always_comb begin
		if (rnd_q < RND_W'(20)) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1md_pkg::K_CH;
		end else if (rnd_q < RND_W'(40)) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1md_pkg::K_PAR1;
		end else if (rnd_q < RND_W'(60)) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1md_pkg::K_MAJ;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1md_pkg::K_PAR2;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + wt;

	assign sum[0] = chain_q[0] + a_q;
	assign sum[1] = chain_q[1] + b_q;
	assign sum[2] = chain_q[2] + c_q;
	assign sum[3] = chain_q[3] + d_q;
	assign sum[4] = chain_q[4] + e_q;

	always_ff @(posedge clk) begin
		if (push_en) begin
			acc_q <= {acc_q[15:0], push_byte};
			if (push_pos[1:0] == 2'b11) begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= {acc_q, push_byte};
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wt;
		end
		if (start_round) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (fold_emit) begin
			hash_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rnd_q        <= '0;
			byte_count_q <= '0;
			pad_q        <= '0;
			first_q      <= 1'b0;
			len_phase_q  <= 1'b0;
			done_q       <= 1'b0;
			pad_mode_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			chain_q[0]   <= sha1md_pkg::INIT_H0;
			chain_q[1]   <= sha1md_pkg::INIT_H1;
			chain_q[2]   <= sha1md_pkg::INIT_H2;
			chain_q[3]   <= sha1md_pkg::INIT_H3;
			chain_q[4]   <= sha1md_pkg::INIT_H4;
		end else begin
			if (fold_emit) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (msg_fire) begin
						if (msg.byte_valid) begin
							byte_count_q <= byte_count_q + 64'd1;
						end
						pad_q       <= new_pos;
						first_q     <= 1'b1;
						len_phase_q <= (new_pos < 6'(sha1md_pkg::LEN_POS));
						done_q      <= 1'b0;
						pad_mode_q  <= msg.last;
						if (start_round) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
						end else if (msg.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_q   <= pad_q + 6'd1;
					first_q <= 1'b0;
					if (start_round) begin
						if (len_phase_q) begin
							done_q <= 1'b1;
						end else begin
							len_phase_q <= 1'b1;
						end
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + RND_W'(1);
					if (rnd_q == RND_W'(sha1md_pkg::ROUNDS - 1)) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (fold_emit) begin
						chain_q[0]   <= sha1md_pkg::INIT_H0;
						chain_q[1]   <= sha1md_pkg::INIT_H1;
						chain_q[2]   <= sha1md_pkg::INIT_H2;
						chain_q[3]   <= sha1md_pkg::INIT_H3;
						chain_q[4]   <= sha1md_pkg::INIT_H4;
						byte_count_q <= '0;
						pad_mode_q   <= 1'b0;
						done_q       <= 1'b0;
						state_q      <= ST_IDLE;
					end else if (!done_q) begin
						chain_q <= sum;
						state_q <= pad_mode_q ? ST_PAD : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q < RND_W'(sha1md_pkg::ROUNDS)))
		else $error("round counter out of range");

	a_round_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) ##1 (state_q == ST_ROUND) |-> (rnd_q == '0))
		else $error("compression started mid-count");

	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (len_phase_q && pad_mode_q))
		else $error("final block flagged without length phase");

	a_emit_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fold_emit |=> (byte_count_q == '0) && (chain_q[0] == sha1md_pkg::INIT_H0)
			&& out_valid_q)
		else $error("digest issued without returning to initial state");
`endif

endmodule
